// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising clock edge, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- sv/ps2mct_pkg.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Packet phase type, register indexes and fixed protocol constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ps2mct_pkg;

   // Framing phase of the byte stream.
   typedef enum logic [1:0] {
      PH_ACK   = 2'd0,
      PH_HEAD  = 2'd1,
      PH_XBYTE = 2'd2,
      PH_YBYTE = 2'd3
   } phase_type;

   // Configuration register indexes.
   typedef enum logic {
      REG_X_LIMIT = 1'b0,
      REG_Y_LIMIT = 1'b1
   } reg_index_type;

   // Protocol constants.
   localparam logic [7:0] ACK_BYTE   = 8'hFA;
   localparam logic [7:0] SYNC_MASK  = 8'hC8;
   localparam logic [7:0] SYNC_VALUE = 8'h08;
   localparam int unsigned X_SIGN_POS = 4;
   localparam int unsigned Y_SIGN_POS = 5;

   // Cursor geometry.
   localparam int unsigned POS_W = 12;
   localparam logic [POS_W-1:0] X_LIMIT_RESET = 12'd304;
   localparam logic [POS_W-1:0] Y_LIMIT_RESET = 12'd184;

   // Port widths.
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

endpackage

// ----- sv/ps2_mouse_packet_cursor_tracker_top.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker
// Frames mouse bytes into three-byte packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// The block takes one mouse byte per cycle. It ignores bytes until the
// acknowledge byte 0xFA, then frames three-byte packets, skipping first
// bytes that fail the sync test. The third byte of a packet produces one
// result item in the next cycle, carrying the buttons, the signed movements
// (Y negated so downward is positive) and the cursor position clamped to
// 0..limit on each axis. Every byte is decoded by combinational logic into
// the state and result registers, so the sustained rate is one item per
// cycle; only a packet-completing byte waits while an earlier result is
// still held in the output register. Cursor limits are set through the
// APB-style port at byte addresses 0 (x_limit) and 4 (y_limit).
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ps2_mouse_packet_cursor_tracker_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] rx_byte
   input  logic [ps2mct_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [2:0] buttons, [11:3] move_x, [21:12] move_y, [33:22] cursor_x,
   // [45:34] cursor_y, [47:46] zero
   output logic [ps2mct_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ps2mct_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ps2mct_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ps2mct_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   localparam int unsigned PW = ps2mct_pkg::POS_W;
   localparam int unsigned SW = PW + 2;

   // State and result registers.
   ps2mct_pkg::phase_type phase_ff, phase_in;
   logic [7:0]    header_ff, header_in;
   logic [7:0]    xbyte_ff, xbyte_in;
   logic [PW-1:0] pos_x_ff, pos_x_in;
   logic [PW-1:0] pos_y_ff, pos_y_in;
   logic [PW-1:0] x_limit_ff, y_limit_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_buttons_ff;
   logic [8:0]    rsp_move_x_ff;
   logic [9:0]    rsp_move_y_ff;
   logic [PW-1:0] rsp_cursor_x_ff;
   logic [PW-1:0] rsp_cursor_y_ff;

   // Handshake and decode signals.
   logic          req_fire;
   logic          result_load;
   logic          csr_write;
   ps2mct_pkg::reg_index_type csr_index;
   logic [7:0]    rx_byte;
   logic signed [8:0]  move_x;
   logic signed [9:0]  y_raw;
   logic signed [9:0]  move_y;
   logic signed [SW-1:0] sum_x;
   logic signed [SW-1:0] sum_y;

   assign rx_byte = req_tdata[7:0];

   // A byte that does not finish a packet is always taken; a third byte
   // needs room in the result register.
   assign req_tready  = (phase_ff != ps2mct_pkg::PH_YBYTE) || !rsp_valid_ff || rsp_tready;
   assign req_fire    = req_tvalid && req_tready;
   assign result_load = req_fire && (phase_ff == ps2mct_pkg::PH_YBYTE);

   // Next framing state.
   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      xbyte_in  = xbyte_ff;
      if (req_fire) begin
         unique case (phase_ff)
            ps2mct_pkg::PH_ACK: begin
               if (rx_byte == ps2mct_pkg::ACK_BYTE) begin
                  phase_in = ps2mct_pkg::PH_HEAD;
               end
            end
            ps2mct_pkg::PH_HEAD: begin
               if ((rx_byte & ps2mct_pkg::SYNC_MASK) == ps2mct_pkg::SYNC_VALUE) begin
                  header_in = rx_byte;
                  phase_in  = ps2mct_pkg::PH_XBYTE;
               end
            end
            ps2mct_pkg::PH_XBYTE: begin
               xbyte_in = rx_byte;
               phase_in = ps2mct_pkg::PH_YBYTE;
            end
            ps2mct_pkg::PH_YBYTE: begin
               phase_in = ps2mct_pkg::PH_HEAD;
            end
            default: begin
               phase_in = ps2mct_pkg::PH_ACK;
            end
         endcase
      end
   end

   // Movement decode and cursor update for the third byte of a packet.
   always_comb begin
      move_x = $signed({header_ff[ps2mct_pkg::X_SIGN_POS], xbyte_ff});
      y_raw  = $signed({header_ff[ps2mct_pkg::Y_SIGN_POS],
                        header_ff[ps2mct_pkg::Y_SIGN_POS], rx_byte});
      move_y = -y_raw;
      sum_x  = $signed({2'b00, pos_x_ff}) + $signed({{(SW-9){move_x[8]}}, move_x});
      sum_y  = $signed({2'b00, pos_y_ff}) + $signed({{(SW-10){move_y[9]}}, move_y});

      // Below zero clamps to zero, above the limit clamps to the limit.
      if (sum_x < 0) begin
         pos_x_in = '0;
      end else if (sum_x[SW-2:0] > {1'b0, x_limit_ff}) begin
         pos_x_in = x_limit_ff;
      end else begin
         pos_x_in = sum_x[PW-1:0];
      end

      if (sum_y < 0) begin
         pos_y_in = '0;
      end else if (sum_y[SW-2:0] > {1'b0, y_limit_ff}) begin
         pos_y_in = y_limit_ff;
      end else begin
         pos_y_in = sum_y[PW-1:0];
      end

      rsp_valid_in = result_load || (rsp_valid_ff && !rsp_tready);
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ps2mct_pkg::PH_ACK;
         header_ff    <= '0;
         xbyte_ff     <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         header_ff    <= header_in;
         xbyte_ff     <= xbyte_in;
         rsp_valid_ff <= rsp_valid_in;
         if (result_load) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_buttons_ff  <= header_ff[2:0];
         rsp_move_x_ff   <= move_x;
         rsp_move_y_ff   <= move_y;
         rsp_cursor_x_ff <= pos_x_in;
         rsp_cursor_y_ff <= pos_y_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_cursor_y_ff, rsp_cursor_x_ff, rsp_move_y_ff,
                        rsp_move_x_ff, rsp_buttons_ff};

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = ps2mct_pkg::reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= ps2mct_pkg::X_LIMIT_RESET;
         y_limit_ff <= ps2mct_pkg::Y_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            ps2mct_pkg::REG_X_LIMIT: x_limit_ff <= csr_pwdata[PW-1:0];
            ps2mct_pkg::REG_Y_LIMIT: y_limit_ff <= csr_pwdata[PW-1:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_index)
         ps2mct_pkg::REG_X_LIMIT: csr_prdata = {{(ps2mct_pkg::CSR_DATA_W-PW){1'b0}}, x_limit_ff};
         ps2mct_pkg::REG_Y_LIMIT: csr_prdata = {{(ps2mct_pkg::CSR_DATA_W-PW){1'b0}}, y_limit_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // Assertions.
   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (phase_ff == ps2mct_pkg::PH_ACK) && !rsp_valid_ff, "reset did not clear framing and result state")
   `ASSERT_CLK(a_no_overwrite, clock, reset, (rsp_valid_ff && !rsp_tready) |-> !result_load, "held result overwritten by a new packet")
   `ASSERT_CLK(a_cursor_in_limit, clock, reset, result_load |=> (rsp_cursor_x_ff <= $past(x_limit_ff)) && (rsp_cursor_y_ff <= $past(y_limit_ff)), "cursor result exceeds its limit")
   `ASSERT_CLK(a_cursor_tracks, clock, reset, rsp_valid_ff |-> (rsp_cursor_x_ff == pos_x_ff) && (rsp_cursor_y_ff == pos_y_ff), "pending result disagrees with kept position")

endmodule

// ----- tb/ps2_mouse_packet_cursor_tracker_top_tb.sv -----
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker testbench
// Feeds mouse byte streams under random flow control. A scoreboard class
// tracks the packet framing and the clamped cursor, and checks every result.
// ----------------------------------------------------------------------------
// The run opens with a directed stream: bytes before the acknowledge, a
// repeated acknowledge, failed sync bytes and packets with extreme movements
// and six of the eight button patterns. Random phases follow, each with
// new cursor limits written through the APB-style port while the block is
// idle. Most random bytes form well-formed packets; the rest are noise and
// truncated packets. Once in the run the result side holds off for a long
// stretch so that the block backs up and stalls its input.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_top_tb;

   // One decoded packet as it appears on the result channel, LSB field last.
   typedef struct packed {
      logic [ps2mct_pkg::POS_W-1:0] cursor_y;
      logic [ps2mct_pkg::POS_W-1:0] cursor_x;
      logic signed [9:0]            move_y;
      logic signed [8:0]            move_x;
      logic [2:0]                   buttons;
   } cursor_report_type;

   // Tracks framing and cursor position, and holds the reports still due.
   class cursor_scoreboard;
      ps2mct_pkg::phase_type        phase;
      logic [7:0]                   head;
      logic [7:0]                   xb;
      logic [ps2mct_pkg::POS_W-1:0] pos_x;
      logic [ps2mct_pkg::POS_W-1:0] pos_y;
      logic [ps2mct_pkg::POS_W-1:0] x_lim;
      logic [ps2mct_pkg::POS_W-1:0] y_lim;
      cursor_report_type            due_reports[$];
      int                           n_faults;

      function new();
         phase    = ps2mct_pkg::PH_ACK;
         head     = '0;
         xb       = '0;
         pos_x    = '0;
         pos_y    = '0;
         x_lim    = ps2mct_pkg::X_LIMIT_RESET;
         y_lim    = ps2mct_pkg::Y_LIMIT_RESET;
         n_faults = 0;
      endfunction

      function void set_limit(ps2mct_pkg::reg_index_type idx,
                              logic [ps2mct_pkg::POS_W-1:0] val);
         if (idx == ps2mct_pkg::REG_X_LIMIT)
            x_lim = val;
         else
            y_lim = val;
      endfunction

      // Add a movement to one axis, then clamp low first and high second.
      function logic [ps2mct_pkg::POS_W-1:0] step_axis(
            logic [ps2mct_pkg::POS_W-1:0] pos, int delta,
            logic [ps2mct_pkg::POS_W-1:0] lim);
         int sum;
         sum = int'(pos) + delta;
         if (sum < 0)
            sum = 0;
         if (sum > int'(lim))
            sum = int'(lim);
         return sum[ps2mct_pkg::POS_W-1:0];
      endfunction

      function void note_fault();
         n_faults++;
      endfunction

      // Advance the framing by one accepted byte.
      function void track_byte(logic [7:0] rx);
         int                dx;
         int                dy;
         cursor_report_type rep;
         case (phase)
            ps2mct_pkg::PH_ACK: begin
               if (rx == ps2mct_pkg::ACK_BYTE)
                  phase = ps2mct_pkg::PH_HEAD;
            end
            ps2mct_pkg::PH_HEAD: begin
               if ((rx & ps2mct_pkg::SYNC_MASK) == ps2mct_pkg::SYNC_VALUE) begin
                  head  = rx;
                  phase = ps2mct_pkg::PH_XBYTE;
               end
            end
            ps2mct_pkg::PH_XBYTE: begin
               xb    = rx;
               phase = ps2mct_pkg::PH_YBYTE;
            end
            default: begin
               phase = ps2mct_pkg::PH_HEAD;
               dx    = int'(xb) - (head[ps2mct_pkg::X_SIGN_POS] ? 256 : 0);
               // Y is negated so that downward is positive.
               dy    = (head[ps2mct_pkg::Y_SIGN_POS] ? 256 : 0) - int'(rx);
               pos_x = step_axis(pos_x, dx, x_lim);
               pos_y = step_axis(pos_y, dy, y_lim);
               rep.buttons  = head[2:0];
               rep.move_x   = dx[8:0];
               rep.move_y   = dy[9:0];
               rep.cursor_x = pos_x;
               rep.cursor_y = pos_y;
               due_reports.push_back(rep);
            end
         endcase
      endfunction

      // Compare one result item with the oldest report due.
      function void check_report(logic [ps2mct_pkg::RSP_DATA_W-1:0] data);
         cursor_report_type got;
         cursor_report_type want;
         got = data[$bits(cursor_report_type)-1:0];
         if (due_reports.size() == 0) begin
            if (n_faults < 10)
               $display("%0t: result with none due: buttons=%0d move_x=%0d %s",
                        $realtime, got.buttons, got.move_x,
                        $sformatf("move_y=%0d x=%0d y=%0d", got.move_y,
                                  got.cursor_x, got.cursor_y));
            n_faults++;
         end else begin
            want = due_reports.pop_front();
            if (got.buttons !== want.buttons || got.move_x !== want.move_x ||
                got.move_y !== want.move_y || got.cursor_x !== want.cursor_x ||
                got.cursor_y !== want.cursor_y) begin
               if (n_faults < 10) begin
                  $display("%0t: report mismatch", $realtime);
                  $display("   exp buttons=%0d move_x=%0d move_y=%0d x=%0d y=%0d",
                           want.buttons, want.move_x, want.move_y,
                           want.cursor_x, want.cursor_y);
                  $display("   got buttons=%0d move_x=%0d move_y=%0d x=%0d y=%0d",
                           got.buttons, got.move_x, got.move_y,
                           got.cursor_x, got.cursor_y);
               end
               n_faults++;
            end
         end
      endfunction
   endclass

   // Result side flow-control patterns.
   typedef enum {RX_OPEN, RX_CHOPPY, RX_SLOW} drain_mode_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [ps2mct_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [ps2mct_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [ps2mct_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [ps2mct_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [ps2mct_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                              csr_pready;

   cursor_scoreboard sb = new();

   logic [7:0]     byte_q[$];
   int             n_queued = 0;
   int             n_accepted = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             hold_left = 0;
   bit             held_once = 1'b0;
   int             seg_left = 0;
   drain_mode_type drain_mode = RX_OPEN;

   ps2_mouse_packet_cursor_tracker_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Byte sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (byte_q.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= byte_q.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: segments of its own pattern, plus one long hold-off.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!held_once && n_accepted >= 350) begin
         held_once = 1'b1;
         hold_left = 400;
         rsp_tready <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_left   = $urandom_range(10, 120);
            drain_mode = drain_mode_type'($urandom_range(0, 2));
         end
         seg_left--;
         case (drain_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_CHOPPY: rsp_tready <= 1'($urandom_range(0, 1));
            default:   rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Monitor: predict on each accepted byte, then check any accepted result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.track_byte(req_tdata);
            n_accepted++;
         end
         if (rsp_tvalid && rsp_tready)
            sb.check_report(rsp_tdata);
      end
   end

   function automatic void push_byte(logic [7:0] b);
      byte_q.push_back(b);
      n_queued++;
   endfunction

   function automatic void push_packet(logic [7:0] hdr, logic [7:0] xv,
                                       logic [7:0] yv);
      push_byte(hdr);
      push_byte(xv);
      push_byte(yv);
   endfunction

   // A movement byte: full range, or a small step matching the sign bit.
   function automatic logic [7:0] pick_move(logic negative);
      if ($urandom_range(0, 1) == 0)
         return 8'($urandom_range(0, 255));
      else if (negative)
         return 8'(256 - $urandom_range(1, 16));
      else
         return 8'($urandom_range(0, 16));
   endfunction

   // A random header that always passes the sync test.
   function automatic logic [7:0] pick_header();
      logic [7:0] hdr;
      hdr = 8'($urandom_range(0, 255));
      return (hdr & ~ps2mct_pkg::SYNC_MASK) | ps2mct_pkg::SYNC_VALUE;
   endfunction

   // One APB-style transfer: setup cycle, then access until pready.
   task automatic csr_access(input logic wr, input ps2mct_pkg::reg_index_type idx,
                             input logic [ps2mct_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [ps2mct_pkg::CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Write one limit, track it, and read it back.
   task automatic program_limit(ps2mct_pkg::reg_index_type idx,
                                logic [ps2mct_pkg::POS_W-1:0] val);
      logic [ps2mct_pkg::CSR_DATA_W-1:0] rd;
      csr_access(1'b1, idx,
                 {{(ps2mct_pkg::CSR_DATA_W-ps2mct_pkg::POS_W){1'b0}}, val}, rd);
      sb.set_limit(idx, val);
      csr_access(1'b0, idx, '0, rd);
      if (rd[ps2mct_pkg::POS_W-1:0] !== val) begin
         if (sb.n_faults < 10)
            $display("%0t: limit readback %s exp=%0d got=%0d", $realtime,
                     idx.name(), val, rd[ps2mct_pkg::POS_W-1:0]);
         sb.note_fault();
      end
   endtask

   // Wait until every byte is taken and every report has arrived.
   task automatic wait_drained();
      while (n_accepted != n_queued || sb.due_reports.size() != 0)
         @(posedge clock);
      // A byte that completes no packet may still be settling.
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [ps2mct_pkg::POS_W-1:0] xl;
      logic [ps2mct_pkg::POS_W-1:0] yl;
      int                           target;
      int                           pick;
      logic [7:0]                   hdr;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bytes before the acknowledge, one of them a valid-looking header.
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(ps2mct_pkg::SYNC_VALUE);
      push_byte(8'hFB);
      push_byte(ps2mct_pkg::ACK_BYTE);
      // A second acknowledge and failed sync bytes are skipped.
      push_byte(ps2mct_pkg::ACK_BYTE);
      push_byte(8'hC8);
      push_byte(8'h48);
      push_byte(8'h80);
      // Largest positive X, most negative Y step: Y clamps at zero.
      push_packet(8'h0F, 8'hFF, 8'hFF);
      // Most negative X and largest downward Y: X to zero, Y to the limit.
      push_packet(8'h38, 8'h00, 8'h00);
      push_packet(8'h09, 8'h7F, 8'h80);
      push_packet(8'h3C, 8'h01, 8'hFE);
      push_packet(8'h0A, 8'h10, 8'h00);
      push_packet(8'h0B, 8'h00, 8'h01);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin xl = 12'd4095; yl = 12'd4095; end
            // Lowered below the current position: next packet clamps it.
            1: begin xl = 12'd9;    yl = 12'd5;    end
            2: begin xl = 12'd0;    yl = 12'd0;    end
            3: begin xl = 12'd4095; yl = 12'd1;    end
            4: begin
               xl = 12'($urandom_range(0, 4095));
               yl = 12'($urandom_range(0, 4095));
            end
            default: begin
               xl = 12'($urandom_range(0, 400));
               yl = 12'($urandom_range(0, 400));
            end
         endcase
         program_limit(ps2mct_pkg::REG_X_LIMIT, xl);
         program_limit(ps2mct_pkg::REG_Y_LIMIT, yl);

         target = n_queued + 115;
         while (n_queued < target) begin
            pick = $urandom_range(0, 9);
            hdr  = pick_header();
            if (pick < 8) begin
               push_packet(hdr, pick_move(hdr[ps2mct_pkg::X_SIGN_POS]),
                           pick_move(hdr[ps2mct_pkg::Y_SIGN_POS]));
            end else if (pick == 8) begin
               // Noise, which may shift the framing.
               repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
            end else begin
               // Truncated packet.
               push_byte(hdr);
               if ($urandom_range(0, 1) == 1)
                  push_byte(pick_move(hdr[ps2mct_pkg::X_SIGN_POS]));
            end
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (sb.n_faults == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Run limit.
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
